>>> rtl/first_fit_free_list_allocator_top_assert.svh
// assertion macros shared by the allocator rtl
// depends on nothing; included by the modules that carry checks
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("allocator check failed");
`define FFA_ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("allocator check failed");
`else
`define FFA_ASSERT_RST(lbl, clk, rst, prop)
`define FFA_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

>>> rtl/ffa_pkg.sv
// types and codes of the first-fit allocator
// no dependencies; used by the rtl modules and interfaces
package ffa_pkg;
  localparam int CMD_W    = 2;
  localparam int DATA_W   = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_RELFAIL = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_INIT,
    OP_ARD,
    OP_AFIRST,
    OP_AEVAL,
    OP_CARVE,
    OP_RCHK,
    OP_RRD,
    OP_RWALK,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_M4,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    cmd_t cmd;
    logic built;
    logic fit;
    logic exact;
    logic at_rover;
    logic bound;
    logic found;
    logic addr_ok;
  } dp_flags_t;
endpackage

>>> rtl/ffa_ifs.sv
// handshake channels of the allocator: request, response, configuration
// depends on ffa_pkg
interface ffa_req_if;
  import ffa_pkg::*;
  logic valid;
  logic ready;
  logic [CMD_W-1:0] command;
  logic [DATA_W-1:0] request_bytes;
  logic [DATA_W-1:0] release_address;
  modport source(output valid, command, request_bytes, release_address, input ready);
  modport sink(input valid, command, request_bytes, release_address, output ready);
endinterface

interface ffa_rsp_if;
  import ffa_pkg::*;
  logic valid;
  logic ready;
  logic [DATA_W-1:0] block_address;
  logic [STATUS_W-1:0] status;
  modport source(output valid, block_address, status, input ready);
  modport sink(input valid, block_address, status, output ready);
endinterface

interface ffa_cfg_if;
  import ffa_pkg::*;
  logic valid;
  logic ready;
  logic [DATA_W-1:0] heap_base;
  modport source(output valid, heap_base, input ready);
  modport sink(input valid, heap_base, output ready);
endinterface

>>> rtl/ffa_datapath.sv
// header memories, walk registers, divider and result register
// depends on ffa_pkg; driven by ffa_ctrl
module ffa_datapath #(
  parameter int HEAP_UNITS = 4096,
  parameter int UNIT_BYTES = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ffa_pkg::dp_op_t          op,
  output ffa_pkg::dp_flags_t       flags,
  input  logic [1:0]               in_command,
  input  logic [15:0]              in_request_bytes,
  input  logic [15:0]              in_release_address,
  input  logic                     cfg_we,
  input  logic [15:0]              cfg_heap_base,
  output logic [15:0]              block_address,
  output logic [1:0]               status
);
  import ffa_pkg::*;

  localparam int UW = $clog2(HEAP_UNITS);
  localparam int SW = $clog2(HEAP_UNITS + 1);
  localparam int XW = DATA_W + 1;
  localparam int DS = XW + $clog2(UNIT_BYTES);
  localparam int DM = ((1 << DS) + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam int PW = XW + DS;
  localparam int WW = XW + 1;

  logic [SW-1:0] size_mem [HEAP_UNITS];
  logic [UW-1:0] next_mem [HEAP_UNITS];
  logic [SW-1:0] rd_size;
  logic [UW-1:0] rd_next;
  logic [UW-1:0] raddr;
  logic          size_we, next_we;
  logic [UW-1:0] size_wa, next_wa;
  logic [SW-1:0] size_wd;
  logic [UW-1:0] next_wd;

  logic [15:0]   base;
  cmd_t          cmd_reg;
  logic [15:0]   req_reg, rel_reg;
  logic [PW-1:0] prod;
  logic          built;
  logic [UW-1:0] rover, prev, p, bp, nx_reg, bnext, res_unit;
  logic [SW-1:0] n, psize, bsize;
  logic          has_addr;
  status_t       res_status;

  logic [XW-1:0] quot, x;
  logic [WW-1:0] need, sz_w;
  logic [15:0]   d;
  logic          in_heap, fit, exact, at_rover, bound, found, addr_ok;
  logic          div_exact, low_merge, up_merge;
  logic [SW-1:0] remain, new_bsize;
  logic [UW-1:0] carve_at, bp_calc, new_bnext;
  logic [31:0]   addr_off;

  assign quot   = prod[DS +: XW];
  assign need   = {1'b0, quot} + WW'(1);
  assign sz_w   = WW'(rd_size);
  assign d      = rel_reg - base;
  assign x      = (cmd_reg == CMD_ALLOC) ? XW'(req_reg) + XW'(UNIT_BYTES - 1) : XW'(d);
  // blocks that run past the heap end are never handed out
  assign in_heap = (WW'(p) + sz_w) <= WW'(HEAP_UNITS);
  assign exact  = sz_w == need;
  assign fit    = in_heap && (sz_w >= need) && !(exact && (rd_next == p));
  assign remain = rd_size - SW'(need);
  assign carve_at = p + UW'(remain);
  assign at_rover = p == rover;
  assign bound    = n == SW'(HEAP_UNITS);

  assign div_exact = (32'(quot) * 32'(UNIT_BYTES)) == 32'(d);
  assign addr_ok   = built && (quot != '0) && (quot <= XW'(HEAP_UNITS)) && div_exact;
  assign bp_calc   = UW'(quot - XW'(1));
  // free list is address ordered; the wrap link is the top-to-bottom one
  assign found = ((bp > p) && (bp < rd_next)) ||
                 ((p >= rd_next) && ((bp > p) || (bp < rd_next)));

  assign low_merge = (WW'(bp) + WW'(bsize)) == WW'(nx_reg);
  assign new_bsize = low_merge ? bsize + rd_size : bsize;
  assign new_bnext = low_merge ? rd_next : nx_reg;
  assign up_merge  = (WW'(p) + WW'(psize)) == WW'(bp);
  assign addr_off  = (32'(res_unit) + 32'd1) * 32'(UNIT_BYTES);

  assign flags = '{cmd: cmd_reg, built: built, fit: fit, exact: exact,
                   at_rover: at_rover, bound: bound, found: found, addr_ok: addr_ok};

  always_comb begin
    raddr   = rover;
    size_we = 1'b0;
    next_we = 1'b0;
    size_wa = p;
    next_wa = p;
    size_wd = rd_size;
    next_wd = rd_next;
    case (op)
      OP_INIT: begin
        size_we = 1'b1;
        next_we = 1'b1;
        size_wa = '0;
        next_wa = '0;
        size_wd = SW'(HEAP_UNITS);
        next_wd = '0;
      end
      OP_AFIRST: raddr = rd_next;
      OP_AEVAL: begin
        raddr = rd_next;
        if (fit && exact) begin
          next_we = 1'b1;
          next_wa = prev;
          next_wd = rd_next;
        end else if (fit) begin
          size_we = 1'b1;
          size_wa = p;
          size_wd = remain;
        end
      end
      OP_CARVE: begin
        size_we = 1'b1;
        size_wa = res_unit;
        size_wd = SW'(need);
      end
      OP_RWALK: raddr = rd_next;
      OP_M1:    raddr = bp;
      OP_M2:    raddr = nx_reg;
      OP_M3: begin
        size_we = 1'b1;
        next_we = 1'b1;
        size_wa = bp;
        next_wa = bp;
        size_wd = new_bsize;
        next_wd = new_bnext;
      end
      OP_M4: begin
        size_we = up_merge;
        next_we = 1'b1;
        size_wa = p;
        next_wa = p;
        size_wd = psize + bsize;
        next_wd = up_merge ? bnext : bp;
      end
      default: raddr = rover;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_size <= size_mem[raddr];
    rd_next <= next_mem[raddr];
    if (size_we) size_mem[size_wa] <= size_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= '0;
      built <= 1'b0;
      rover <= '0;
    end else begin
      if (cfg_we) base <= cfg_heap_base;
      case (op)
        OP_LOAD: begin
          if (cmd_t'(in_command) == CMD_CLEAR) begin
            built <= 1'b0;
            rover <= '0;
          end
        end
        OP_INIT: begin
          built <= 1'b1;
          rover <= '0;
        end
        OP_AEVAL: if (fit) rover <= prev;
        OP_M4:    rover <= p;
        default:  rover <= rover;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cmd_reg    <= cmd_t'(in_command);
        req_reg    <= in_request_bytes;
        rel_reg    <= in_release_address;
        has_addr   <= 1'b0;
        res_status <= ST_OK;
      end
      OP_DIV: prod <= PW'(x) * PW'(DM);
      OP_AFIRST: begin
        prev <= rover;
        p    <= rd_next;
        n    <= '0;
      end
      OP_AEVAL: begin
        if (fit) begin
          res_unit   <= exact ? p : carve_at;
          has_addr   <= 1'b1;
          res_status <= ST_OK;
        end else if (at_rover || bound) begin
          res_status <= ST_OOM;
        end else begin
          prev <= p;
          p    <= rd_next;
          n    <= n + SW'(1);
        end
      end
      OP_RCHK: begin
        bp <= bp_calc;
        if (!addr_ok) res_status <= ST_RELFAIL;
      end
      OP_RRD: begin
        p <= rover;
        n <= '0;
      end
      OP_RWALK: begin
        if (found) begin
          psize  <= rd_size;
          nx_reg <= rd_next;
        end else if (bound) begin
          res_status <= ST_RELFAIL;
        end else begin
          p <= rd_next;
          n <= n + SW'(1);
        end
      end
      OP_M2: bsize <= rd_size;
      OP_M3: begin
        bsize <= new_bsize;
        bnext <= new_bnext;
      end
      OP_EMIT: begin
        block_address <= has_addr ? base + addr_off[15:0] : '0;
        status        <= res_status;
      end
      default: prev <= prev;
    endcase
  end
endmodule

>>> rtl/ffa_ctrl.sv
// sequencer of the allocator: steps the datapath and owns the handshakes
// depends on ffa_pkg and the assertion header
`include "first_fit_free_list_allocator_top_assert.svh"
module ffa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  output logic               out_valid,
  input  logic               out_ready,
  input  ffa_pkg::dp_flags_t flags,
  output ffa_pkg::dp_op_t    op
);
  import ffa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_INIT, S_ARD, S_AFIRST, S_AEVAL, S_CARVE,
    S_RCHK, S_RRD, S_RWALK, S_M1, S_M2, S_M3, S_M4, S_DONE
  } state_t;

  state_t state, state_next;
  logic   emit;

  assign in_ready = state == S_IDLE;
  assign emit     = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    op         = OP_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
          if (cmd_t'(in_command) == CMD_ALLOC || cmd_t'(in_command) == CMD_RELEASE) begin
            state_next = S_DIV;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DIV: begin
        op = OP_DIV;
        if (flags.cmd == CMD_ALLOC) state_next = flags.built ? S_ARD : S_INIT;
        else state_next = S_RCHK;
      end
      S_INIT: begin
        op = OP_INIT;
        state_next = S_ARD;
      end
      S_ARD: begin
        op = OP_ARD;
        state_next = S_AFIRST;
      end
      S_AFIRST: begin
        op = OP_AFIRST;
        state_next = S_AEVAL;
      end
      S_AEVAL: begin
        op = OP_AEVAL;
        if (flags.fit) state_next = flags.exact ? S_DONE : S_CARVE;
        else if (flags.at_rover || flags.bound) state_next = S_DONE;
      end
      S_CARVE: begin
        op = OP_CARVE;
        state_next = S_DONE;
      end
      S_RCHK: begin
        op = OP_RCHK;
        state_next = flags.addr_ok ? S_RRD : S_DONE;
      end
      S_RRD: begin
        op = OP_RRD;
        state_next = S_RWALK;
      end
      S_RWALK: begin
        op = OP_RWALK;
        if (flags.found) state_next = S_M1;
        else if (flags.bound) state_next = S_DONE;
      end
      S_M1: begin
        op = OP_M1;
        state_next = S_M2;
      end
      S_M2: begin
        op = OP_M2;
        state_next = S_M3;
      end
      S_M3: begin
        op = OP_M3;
        state_next = S_M4;
      end
      S_M4: begin
        op = OP_M4;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (emit) begin
          op = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // one item at a time: a transfer closes the input until the result is out
  `FFA_ASSERT_RST(a_one_in_flight, clk, rst, (in_valid && in_ready) |=> !in_ready)
  // a waiting result is never overwritten
  `FFA_ASSERT_RST(a_no_overwrite, clk, rst, (op == OP_EMIT) |-> (!out_valid || out_ready))
  // a new result only follows the finishing state
  `FFA_ASSERT_RST(a_rise_after_done, clk, rst, $rose(out_valid) |-> $past(state == S_DONE))
  // a carve always follows a fitting evaluation
  `FFA_ASSERT_CLK(a_carve_src, clk, (state == S_CARVE) |-> $past(state == S_AEVAL))
endmodule

>>> rtl/first_fit_free_list_allocator_top.sv
// First-fit free-list allocator over HEAP_UNITS header units of UNIT_BYTES
// bytes; one response per request. An allocate steps through load, divide,
// a rebuild if unbuilt, read, first, one evaluation per free block visited
// and a carve if cut from a larger block; a release through load, divide,
// address check, read, one walk step per block visited and the merges (none
// if no place is found, no walk if the address is rejected); a reset or
// unknown command goes from load to done. The walk is bounded by the single
// read port of the header memories, one header per cycle; a response waits
// in an output register while the next request is taken. heap_base may be
// written at any idle time. Header memories need no clearing after reset.
// depends on ffa_pkg, ffa_ifs, ffa_ctrl and ffa_datapath
module first_fit_free_list_allocator_top #(
  parameter int HEAP_UNITS = 4096,
  parameter int UNIT_BYTES = 4
) (
  input logic      clk,
  input logic      rst,
  ffa_req_if.sink  req,
  ffa_rsp_if.source rsp,
  ffa_cfg_if.sink  cfg
);
  import ffa_pkg::*;

  dp_op_t    op;
  dp_flags_t flags;

  assign cfg.ready = 1'b1;

  ffa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_command (req.command),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .flags      (flags),
    .op         (op)
  );

  ffa_datapath #(
    .HEAP_UNITS (HEAP_UNITS),
    .UNIT_BYTES (UNIT_BYTES)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .op                 (op),
    .flags              (flags),
    .in_command         (req.command),
    .in_request_bytes   (req.request_bytes),
    .in_release_address (req.release_address),
    .cfg_we             (cfg.valid),
    .cfg_heap_base      (cfg.heap_base),
    .block_address      (rsp.block_address),
    .status             (rsp.status)
  );
endmodule
